// ===== rtl/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared widths, codes and word types of the text terminal cursor buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

	localparam int MAX_COLS   = 80;
	localparam int MAX_ROWS   = 25;
	localparam int STORE_SIZE = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CHAR_W    = 8;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	localparam logic [COL_W-1:0] RESET_COLS = 7'd21;
	localparam logic [ROW_W-1:0] RESET_ROWS = 5'd8;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  cell_row;
		logic [COL_W-1:0]  cell_col;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
		logic [CHAR_W-1:0] read_char;
		logic              range_error;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/ttcb_cell_store.sv =====
// ----------------------------------------------------------------------------
// ttcb_cell_store
// Character cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_cell_store
	import ttcb_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [STORE_SIZE];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_cursor_buffer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_buffer
// Character terminal store with cursor, line wrap and upward scroll.
// ----------------------------------------------------------------------------
// All cells live in one single-port-write, single-port-read memory, so the
// cost of a word is set by how many cells it touches. Before the next word is
// taken, a put is accepted, writes its cell and hands its result on to the
// result register; a read reads its cell instead; a newline, an off-screen
// read or an unused kind is accepted and hands off. A scrolling put or newline
// copies rows 1 and up one row higher and fills the last row with spaces, one
// cell a cycle. A clear sweeps all 2000 cells; the same pass runs after reset
// with cmd_stall high, and configuration writes are taken throughout. Each
// result leaves through a pending register and the rsp register, so a new
// word is accepted while an earlier result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_buffer
	import ttcb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire cmd_t                 cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PUTW  = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_COPY  = 7'b0010000,
		ST_FILL  = 7'b0100000,
		ST_CLEAR = 7'b1000000
	} state_t;

	localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_SIZE - 1);

	state_t            state_q;
	logic [COL_W-1:0]  col_q, cols_q;
	logic [ROW_W-1:0]  line_q, rows_q;
	logic [CHAR_W-1:0] char_q;
	logic              scr_q, put_q;
	logic [ADDR_W-1:0] ptr_q, span_q, wa_s1;
	logic              cp_v_s1;
	logic              pend_q;
	rsp_t              res_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	mem_req_t          mem_req;
	logic [CHAR_W-1:0] cell_rdata;

	logic              accept;
	logic [11:0]       rd_prod, wr_prod, span_prod;
	logic [ADDR_W-1:0] rd_addr, wr_addr, cols_ext;
	logic              rd_err, wrap, scroll;
	logic [ROW_W:0]    next_line;
	logic [ROW_W-1:0]  last_line;
	logic [COL_W-1:0]  new_cols;
	logic [ROW_W-1:0]  new_rows;

	function automatic rsp_t mk_rsp(logic [COL_W-1:0] c, logic [ROW_W-1:0] r, logic s,
		logic [CHAR_W-1:0] d, logic e);
		rsp_t w;
		w.cursor_col  = c;
		w.cursor_row  = r;
		w.scrolled    = s;
		w.read_char   = d;
		w.range_error = e;
		return w;
	endfunction

	ttcb_cell_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (cell_rdata)
	);

	assign cmd_stall = (state_q != ST_IDLE) || pend_q;
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cols_ext  = ADDR_W'(cols_q);
	assign rd_prod   = {7'd0, cmd.cell_row} * {5'd0, cols_q};
	assign rd_addr   = rd_prod[ADDR_W-1:0] + ADDR_W'(cmd.cell_col);
	assign wr_prod   = {7'd0, line_q} * {5'd0, cols_q};
	assign wr_addr   = wr_prod[ADDR_W-1:0] + ADDR_W'(col_q);
	assign span_prod = {7'd0, rows_q} * {5'd0, cols_q};
	assign rd_err    = (cmd.cell_row >= rows_q) || (cmd.cell_col >= cols_q);
	assign wrap      = col_q >= cols_q;
	assign next_line = {1'b0, line_q} + 6'd1;
	assign scroll    = next_line >= {1'b0, rows_q};
	assign last_line = rows_q - 5'd1;

	always_comb begin
		if (cfg_data == '0) begin
			new_cols = 7'd1;
		end else if (cfg_data > COL_W'(MAX_COLS)) begin
			new_cols = COL_W'(MAX_COLS);
		end else begin
			new_cols = cfg_data;
		end
		if (cfg_data[ROW_W-1:0] == '0) begin
			new_rows = 5'd1;
		end else if (cfg_data[ROW_W-1:0] > ROW_W'(MAX_ROWS)) begin
			new_rows = ROW_W'(MAX_ROWS);
		end else begin
			new_rows = cfg_data[ROW_W-1:0];
		end
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = ptr_q;
		mem_req.wdata = CH_SPACE;
		mem_req.re    = 1'b0;
		mem_req.raddr = rd_addr;
		case (state_q)
			ST_IDLE: begin
				mem_req.re = accept && (cmd.kind == KIND_READ) && !rd_err;
			end
			ST_PUTW: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = wr_addr;
				mem_req.wdata = char_q;
			end
			ST_COPY: begin
				mem_req.re    = ptr_q < span_q;
				mem_req.raddr = ptr_q;
				mem_req.we    = cp_v_s1;
				mem_req.waddr = wa_s1;
				mem_req.wdata = cell_rdata;
			end
			ST_FILL, ST_CLEAR, ST_INIT: begin
				mem_req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			line_q      <= '0;
			cols_q      <= RESET_COLS;
			rows_q      <= RESET_ROWS;
			ptr_q       <= '0;
			cp_v_s1     <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// result hand-off to the rsp register
			if (pend_q && (!rsp_valid_q || !rsp_stall)) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							KIND_PUT: begin
								if (cmd.char_code == CH_NEWLINE) begin
									col_q <= '0;
									if (scroll) begin
										line_q  <= last_line;
										put_q   <= 1'b0;
										scr_q   <= 1'b1;
										ptr_q   <= cols_ext;
										span_q  <= span_prod[ADDR_W-1:0];
										cp_v_s1 <= 1'b0;
										state_q <= ST_COPY;
									end else begin
										line_q <= next_line[ROW_W-1:0];
										res_q  <= mk_rsp('0, next_line[ROW_W-1:0], 1'b0,
											'0, 1'b0);
										pend_q <= 1'b1;
									end
								end else begin
									char_q <= cmd.char_code;
									if (wrap) begin
										col_q <= '0;
										if (scroll) begin
											line_q  <= last_line;
											put_q   <= 1'b1;
											scr_q   <= 1'b1;
											ptr_q   <= cols_ext;
											span_q  <= span_prod[ADDR_W-1:0];
											cp_v_s1 <= 1'b0;
											state_q <= ST_COPY;
										end else begin
											line_q  <= next_line[ROW_W-1:0];
											scr_q   <= 1'b0;
											state_q <= ST_PUTW;
										end
									end else begin
										scr_q   <= 1'b0;
										state_q <= ST_PUTW;
									end
								end
							end
							KIND_READ: begin
								if (rd_err) begin
									res_q  <= mk_rsp(col_q, line_q, 1'b0, '0, 1'b1);
									pend_q <= 1'b1;
								end else begin
									state_q <= ST_READ;
								end
							end
							KIND_CLEAR: begin
								col_q   <= '0;
								line_q  <= '0;
								ptr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								res_q  <= mk_rsp(col_q, line_q, 1'b0, '0, 1'b0);
								pend_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PUTW: begin
					col_q   <= col_q + 7'd1;
					res_q   <= mk_rsp(col_q + 7'd1, line_q, scr_q, '0, 1'b0);
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					res_q   <= mk_rsp(col_q, line_q, 1'b0, cell_rdata, 1'b0);
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					// read runs one row ahead of the write, so no overlap
					if (ptr_q < span_q) begin
						ptr_q   <= ptr_q + 11'd1;
						wa_s1   <= ptr_q - cols_ext;
						cp_v_s1 <= 1'b1;
					end else begin
						ptr_q   <= span_q - cols_ext;
						cp_v_s1 <= 1'b0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_q + 11'd1;
					if (ptr_q == span_q - 11'd1) begin
						if (put_q) begin
							state_q <= ST_PUTW;
						end else begin
							res_q   <= mk_rsp('0, line_q, 1'b1, '0, 1'b0);
							pend_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + 11'd1;
					if (ptr_q == STORE_LAST) begin
						res_q   <= mk_rsp('0, '0, 1'b0, '0, 1'b0);
						pend_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					ptr_q <= ptr_q + 11'd1;
					if (ptr_q == STORE_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_COLUMNS: begin
						cols_q <= new_cols;
						if (col_q > new_cols) begin
							col_q <= new_cols;
						end
					end
					REG_ROWS: begin
						rows_q <= new_rows;
						if (line_q > new_rows - 5'd1) begin
							line_q <= new_rows - 5'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q != ST_IDLE) && (state_q != ST_READ))
		else $error("cell write outside a write or sweep state");

	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (line_q < rows_q))
		else $error("cursor row beyond rows in use");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_IDLE))
		else $error("pending result while a word is in progress");

	a_cmd_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (cmd_stall || (state_q == ST_IDLE)))
		else $error("word accepted without stall or return to idle");

endmodule

`default_nettype wire
